// File: sv/assert_macros.svh
// Assertion macros shared by the keypad scanner RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad scanner assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define KPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad scanner assertion failed");

`endif

// File: sv/kpd_pkg.sv
// Shared types and constants for the keypad matrix scanner.
// Depends on nothing; imported by kpd_key_sel, keypad_matrix_scanner, kpd_scan_checker and tb_keypad_matrix_scanner.
package kpd_pkg;

  // Keypad geometry and field widths.
  localparam int NUM_ROWS   = 4;
  localparam int NUM_COLS   = 4;
  localparam int ROW_IDX_W  = 2;
  localparam int CODE_W     = 8;
  localparam int MAP_W      = NUM_COLS * CODE_W;
  localparam int LIMIT_W    = 8;
  localparam int FUNC_W     = 2;

  // Debounce counter width and the width used to compare it with the limit.
  localparam int COUNT_BITS = 8;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  // Reset values of the configuration registers.
  localparam logic [LIMIT_W-1:0] FILTER_RESET = LIMIT_W'(50);
  localparam logic [CODE_W-1:0]  NO_KEY_RESET = CODE_W'(255);

  // Stream and configuration word widths.
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = FUNC_W;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Commands carried with each input word.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_ABORT = 2'd2
  } func_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_ROW1 = 3'd0,
    REG_MAP_ROW2 = 3'd1,
    REG_MAP_ROW3 = 3'd2,
    REG_MAP_ROW4 = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_NO_KEY   = 3'd5
  } reg_idx_t;

  typedef logic [MAP_W-1:0] key_map_t;

endpackage

// File: sv/kpd_key_sel.sv
// Key code lookup: picks the row's key map and the lowest high column.
// Depends on kpd_pkg.
module kpd_key_sel (
  input  kpd_pkg::key_map_t                 key_map [kpd_pkg::NUM_ROWS],
  input  logic [kpd_pkg::ROW_IDX_W-1:0]     row_idx,
  input  logic [kpd_pkg::NUM_COLS-1:0]      columns,
  output logic [kpd_pkg::CODE_W-1:0]        key_code
);
  import kpd_pkg::*;

  key_map_t row_map;

  // Priority select of the lowest active column; no column gives column one.
  always_comb begin
    row_map  = key_map[row_idx];
    key_code = row_map[CODE_W-1:0];
    for (int c = NUM_COLS - 1; c >= 0; c--) begin
      if (columns[c]) begin
        key_code = row_map[c*CODE_W +: CODE_W];
      end
    end
  end

endmodule

// File: sv/keypad_matrix_scanner.sv
// Top level of the 4x4 keypad matrix scanner with debounce filtering.
// Depends on kpd_pkg, kpd_key_sel and assert_macros.svh.
//
//   Channel  Direction  Word contents (lowest bit first)
//   in_      sink       tdata: columns[3:0]; tuser: func[1:0]
//   out_     source     tdata: row_drive[3:0], read_done, key_code[7:0]
//   cfg_     sink       cfg_index selects a register, cfg_data holds its value
//
// Each input word is one scan tick: the state and the result word are both
// registered on acceptance. One word is taken every cycle, limited only by
// the single output register. Reset (rst_n low at a clock edge) sets
// the idle phase, clears the key maps, loads a filter limit of 50 and a
// no-key code of 255. While the output register is full and out_tready is
// low, in_tready stays low. cfg_ready is always high.
module keypad_matrix_scanner (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kpd_pkg::IN_DATA_W-1:0]      in_tdata,   // columns[3:0], zero pad
  input  logic [kpd_pkg::IN_USER_W-1:0]      in_tuser,   // func[1:0]
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kpd_pkg::OUT_DATA_W-1:0]     out_tdata,  // row_drive[3:0], read_done,
                                                         // key_code[7:0], zero pad
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import kpd_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SELECT,
    PH_FILTER,
    PH_RELEASE
  } phase_t;

  // Configuration registers.
  key_map_t             key_map_r [NUM_ROWS];
  logic [LIMIT_W-1:0]   filter_limit_r;
  logic [CODE_W-1:0]    no_key_code_r;

  // Scan state.
  phase_t               phase_r, phase_nxt;
  logic [ROW_IDX_W-1:0] row_r, row_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                 reading_r, reading_nxt;
  logic [CODE_W-1:0]    last_key_r, last_key_nxt;
  logic                 key_valid_r, key_valid_nxt;
  logic [NUM_ROWS-1:0]  row_lines_r, row_lines_nxt;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                 in_fire;
  logic                 cfg_fire;
  func_t                func;
  logic [NUM_COLS-1:0]  columns;
  logic [CODE_W-1:0]    sel_code;
  logic [CODE_W-1:0]    code_out;

  assign func      = func_t'(in_tuser[FUNC_W-1:0]);
  assign columns   = in_tdata[NUM_COLS-1:0];
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Key code of the lowest high column on the row being filtered. No command
  // can leave the filter phase in place, so the stored row is the one in use.
  kpd_key_sel u_key_sel (
    .key_map  (key_map_r),
    .row_idx  (row_r),
    .columns  (columns),
    .key_code (sel_code)
  );

  // Command first, then one scan step.
  always_comb begin
    phase_t               ph;
    logic [ROW_IDX_W-1:0] row_cmd;
    logic                 reading_cmd;
    logic [NUM_ROWS-1:0]  row_onehot;

    ph          = phase_r;
    row_cmd     = row_r;
    reading_cmd = reading_r;
    case (func)
      FUNC_START: begin
        ph          = PH_SELECT;
        row_cmd     = '0;
        reading_cmd = 1'b1;
      end
      FUNC_ABORT: begin
        ph          = PH_IDLE;
        reading_cmd = 1'b0;
      end
      default: ;
    endcase

    row_nxt       = row_cmd;
    reading_nxt   = reading_cmd;
    count_nxt     = count_r;
    last_key_nxt  = last_key_r;
    key_valid_nxt = key_valid_r;
    row_lines_nxt = row_lines_r;
    phase_nxt     = ph;
    row_onehot    = NUM_ROWS'(1) << row_cmd;

    case (ph)
      PH_IDLE: begin
        row_lines_nxt = '0;
        reading_nxt   = 1'b0;
      end
      PH_SELECT: begin
        row_lines_nxt = row_onehot;
        count_nxt     = '0;
        phase_nxt     = PH_FILTER;
      end
      PH_FILTER: begin
        if (columns != '0 && CMP_W'(count_r) == CMP_W'(filter_limit_r)) begin
          last_key_nxt  = sel_code;
          key_valid_nxt = 1'b1;
          phase_nxt     = PH_RELEASE;
        end else if (columns == '0) begin
          row_nxt   = row_cmd + ROW_IDX_W'(1);
          phase_nxt = PH_SELECT;
        end else begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end
      default: begin
        if (columns == '0) begin
          row_lines_nxt = row_lines_r & ~row_onehot;
          phase_nxt     = PH_IDLE;
        end
      end
    endcase

    code_out     = key_valid_nxt ? last_key_nxt : no_key_code_r;
    out_data_nxt = OUT_DATA_W'({code_out, !reading_nxt, row_lines_nxt});
  end

  // Scan state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      row_r       <= '0;
      count_r     <= '0;
      reading_r   <= 1'b0;
      last_key_r  <= NO_KEY_RESET;
      key_valid_r <= 1'b0;
      row_lines_r <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        row_r       <= row_nxt;
        count_r     <= count_nxt;
        reading_r   <= reading_nxt;
        last_key_r  <= last_key_nxt;
        key_valid_r <= key_valid_nxt;
        row_lines_r <= row_lines_nxt;
        out_data_r  <= out_data_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        key_map_r[r] <= '0;
      end
      filter_limit_r <= FILTER_RESET;
      no_key_code_r  <= NO_KEY_RESET;
    end else if (cfg_fire) begin
      case (reg_idx_t'(cfg_index))
        REG_MAP_ROW1: key_map_r[0]   <= cfg_data[MAP_W-1:0];
        REG_MAP_ROW2: key_map_r[1]   <= cfg_data[MAP_W-1:0];
        REG_MAP_ROW3: key_map_r[2]   <= cfg_data[MAP_W-1:0];
        REG_MAP_ROW4: key_map_r[3]   <= cfg_data[MAP_W-1:0];
        REG_LIMIT:    filter_limit_r <= cfg_data[LIMIT_W-1:0];
        REG_NO_KEY:   no_key_code_r  <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // At most one row is ever driven.
  `KPD_ASSERT_IMPLY(a_rows_onehot0, clk, rst_n, 1'b1, $onehot0(row_lines_r))
  // The idle phase drives no row; reading clears on the next idle tick.
  `KPD_ASSERT_IMPLY(a_idle_quiet, clk, rst_n, phase_r == PH_IDLE, row_lines_r == '0)
  // Waiting for release only follows an accepted key.
  `KPD_ASSERT_IMPLY(a_release_has_key, clk, rst_n, phase_r == PH_RELEASE, key_valid_r)
  // A start command drives row one and begins filtering.
  `KPD_ASSERT_NEXT(a_start_row_one, clk, rst_n, in_fire && func == FUNC_START,
                   phase_r == PH_FILTER && reading_r && row_lines_r == NUM_ROWS'(1))

endmodule

// File: verif/kpd_scan_checker.sv
// Checker for the keypad matrix scanner: tracks register writes, predicts the
// result word of every accepted tick and compares it with the result stream.
// Depends on kpd_pkg; instantiated beside the scanner by tb_keypad_matrix_scanner.
module kpd_scan_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [kpd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [kpd_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [kpd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [kpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             words_checked,
  output int                             keys_latched
);
  import kpd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SELECT,
    PH_FILTER,
    PH_RELEASE
  } scan_phase_t;

  typedef struct packed {
    logic [NUM_ROWS-1:0] rows;
    logic                idle;
    logic [CODE_W-1:0]   code;
  } scan_word_t;

  // Predicted register contents.
  key_map_t            key_map [NUM_ROWS];
  logic [LIMIT_W-1:0]  limit;
  logic [CODE_W-1:0]   no_key;

  // Predicted scanner state.
  scan_phase_t         phase;
  logic [ROW_IDX_W-1:0] row;
  logic [COUNT_BITS-1:0] count;
  logic                reading;
  logic [CODE_W-1:0]   last_key;
  logic                key_seen;
  logic [NUM_ROWS-1:0] rows;

  scan_word_t          expected_words [$];
  int                  fails = 0;
  int                  checked = 0;
  int                  latched = 0;
  int                  depth = 0;

  assign fail_count    = fails;
  assign pending       = depth;
  assign words_checked = checked;
  assign keys_latched  = latched;

  // One scan tick: the command is applied first, then one step of the scan.
  function automatic scan_word_t scan_tick(logic [FUNC_W-1:0] f, logic [NUM_COLS-1:0] cols);
    scan_word_t w;
    int col;
    if (f == FUNC_START) begin
      phase   = PH_SELECT;
      row     = '0;
      reading = 1'b1;
    end else if (f == FUNC_ABORT) begin
      phase   = PH_IDLE;
      reading = 1'b0;
    end
    case (phase)
      PH_IDLE: begin
        rows    = '0;
        reading = 1'b0;
      end
      PH_SELECT: begin
        rows  = NUM_ROWS'(1) << row;
        count = '0;
        phase = PH_FILTER;
      end
      PH_FILTER: begin
        if (cols != '0 && count == limit) begin
          // The lowest high column wins.
          col = 0;
          for (int i = NUM_COLS - 1; i >= 0; i--) begin
            if (cols[i]) col = i;
          end
          last_key = key_map[row][CODE_W*col +: CODE_W];
          key_seen = 1'b1;
          phase    = PH_RELEASE;
          latched++;
        end else if (cols == '0) begin
          row   = row + 1'b1;
          phase = PH_SELECT;
        end else begin
          count = count + 1'b1;
        end
      end
      default: begin
        // Wait for the key to be let go, then drop the row.
        if (cols == '0) begin
          rows[row] = 1'b0;
          phase     = PH_IDLE;
        end
      end
    endcase
    w.rows = rows;
    w.idle = !reading;
    w.code = key_seen ? last_key : no_key;
    return w;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  // Register writes, predictions on input words, comparisons on result words.
  always @(posedge clk) begin
    scan_word_t want;
    scan_word_t got;
    if (!rst_n) begin
      foreach (key_map[i]) key_map[i] = '0;
      limit    = FILTER_RESET;
      no_key   = NO_KEY_RESET;
      phase    = PH_IDLE;
      row      = '0;
      count    = '0;
      reading  = 1'b0;
      last_key = NO_KEY_RESET;
      key_seen = 1'b0;
      rows     = '0;
      expected_words.delete();
      depth    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAP_ROW1, REG_MAP_ROW2, REG_MAP_ROW3, REG_MAP_ROW4:
            key_map[cfg_index[ROW_IDX_W-1:0]] = cfg_data;
          REG_LIMIT:  limit  = cfg_data[LIMIT_W-1:0];
          REG_NO_KEY: no_key = cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.rows = out_tdata[3:0];
        got.idle = out_tdata[4];
        got.code = out_tdata[12:5];
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
          fails++;
        end else begin
          want = expected_words.pop_front();
          check_field("row_drive", want.rows, got.rows);
          check_field("read_done", want.idle, got.idle);
          check_field("key_code", want.code, got.code);
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_words.push_back(scan_tick(in_tuser, in_tdata[NUM_COLS-1:0]));
      end
      depth = expected_words.size();
    end
  end

endmodule

// File: verif/tb_keypad_matrix_scanner.sv
// Testbench top for the keypad matrix scanner: reset, register settings,
// directed and random scan ticks with random idling on both streams.
// Depends on kpd_pkg, keypad_matrix_scanner and kpd_scan_checker.
module tb_keypad_matrix_scanner;
  import kpd_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int ITEM_TARGET = 620;
  localparam int CALM_AFTER  = 560;
  localparam int CYCLE_LIMIT = 200000;
  localparam reg_idx_t MAP_REGS [NUM_ROWS] = '{REG_MAP_ROW1, REG_MAP_ROW2,
                                                REG_MAP_ROW3, REG_MAP_ROW4};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int words_checked;
  int keys_latched;

  int n_items = 0;
  int n_reads = 0;
  int n_settings = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  logic [LIMIT_W-1:0] cur_limit = FILTER_RESET;

  keypad_matrix_scanner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  kpd_scan_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .keys_latched  (keys_latched)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_keypad_matrix_scanner failed");
      $finish;
    end
  end

  // Result side: stall in random bursts until the last part of the run.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Plain ticks, with the unused command now and then.
  function automatic logic [FUNC_W-1:0] plain_func();
    return ($urandom_range(0, 7) == 0) ? FUNC_SPARE : FUNC_TICK;
  endfunction

  // Offer one tick word and return at the edge that accepts it.
  task automatic send_tick(logic [FUNC_W-1:0] f, logic [NUM_COLS-1:0] cols);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {{(IN_DATA_W - NUM_COLS){1'b0}}, cols};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    n_items++;
    if (n_items >= CALM_AFTER) calm = 1'b1;
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic park();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // The caller lowers cfg_valid after its last write.
  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // A well-formed read: start, pass some empty rows, hold a key long enough
  // to be latched, let it go and return to idle. Some reads are aborted or
  // restarted, and a key may bounce open once in a while.
  task automatic read_session();
    int skips;
    int twist;
    logic [NUM_COLS-1:0] held;
    skips = $urandom_range(0, 5);
    twist = $urandom_range(0, 11);
    send_tick(FUNC_START, NUM_COLS'($urandom));
    repeat (skips) begin
      send_tick(plain_func(), '0);
      send_tick(plain_func(), NUM_COLS'($urandom));
    end
    if (twist == 0) begin
      send_tick(FUNC_ABORT, NUM_COLS'($urandom));
      send_tick(plain_func(), NUM_COLS'($urandom));
    end else begin
      if (twist == 1) send_tick(FUNC_START, NUM_COLS'($urandom));
      for (int k = 0; k <= int'(cur_limit); k++) begin
        held = ($urandom_range(0, 39) == 0) ? '0 : NUM_COLS'($urandom_range(1, 15));
        send_tick(plain_func(), held);
      end
      repeat ($urandom_range(0, 3)) send_tick(plain_func(), NUM_COLS'($urandom_range(1, 15)));
      send_tick(plain_func(), '0);
      repeat ($urandom_range(1, 2)) send_tick(plain_func(), NUM_COLS'($urandom));
    end
    n_reads++;
  endtask

  initial begin
    int phase_no;
    logic [CFG_DATA_W-1:0] value;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle ticks, the unused command, abort while idle, a row
    // walk that wraps from row four to row one, restart and abort mid-read.
    send_tick(FUNC_TICK, 4'h0);
    send_tick(FUNC_SPARE, 4'hF);
    send_tick(FUNC_ABORT, 4'h0);
    send_tick(FUNC_START, 4'h5);
    repeat (4) begin
      send_tick(FUNC_TICK, 4'h0);
      send_tick(FUNC_TICK, 4'h0);
    end
    send_tick(FUNC_TICK, 4'hF);
    send_tick(FUNC_START, 4'h3);
    send_tick(FUNC_ABORT, 4'h9);
    send_tick(FUNC_TICK, 4'h0);

    // No limit, fixed key maps and a new no-key code before any key is read.
    park();
    write_reg(REG_MAP_ROW1, 32'h4433_2211);
    write_reg(REG_MAP_ROW2, 32'h8877_6655);
    write_reg(REG_MAP_ROW3, 32'hCCBB_AA99);
    write_reg(REG_MAP_ROW4, 32'h00FF_EEDD);
    write_reg(REG_LIMIT, 32'h0000_0000);
    write_reg(REG_NO_KEY, 32'h0000_005A);
    cfg_valid <= 1'b0;
    cur_limit = '0;
    n_settings++;
    send_tick(FUNC_TICK, 4'h0);
    send_tick(FUNC_START, 4'h0);
    send_tick(FUNC_TICK, 4'h8);
    send_tick(FUNC_TICK, 4'hC);
    send_tick(FUNC_TICK, 4'h0);
    send_tick(FUNC_TICK, 4'h0);

    // Random settings, each followed by a batch of reads and some noise.
    // The second setting uses the largest limit.
    phase_no = 0;
    while (n_items < ITEM_TARGET) begin
      park();
      if (phase_no == 1) cur_limit = '1;
      else if ($urandom_range(0, 9) == 0) cur_limit = FILTER_RESET;
      else cur_limit = LIMIT_W'($urandom_range(0, 6));
      value = $urandom;
      value[LIMIT_W-1:0] = cur_limit;
      write_reg(REG_LIMIT, value);
      foreach (MAP_REGS[r]) begin
        if (phase_no == 0 || $urandom_range(0, 1) == 0) write_reg(MAP_REGS[r], $urandom);
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_NO_KEY, $urandom);
      cfg_valid <= 1'b0;
      n_settings++;
      repeat ((cur_limit > 20) ? 1 : $urandom_range(4, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4))
            send_tick(FUNC_W'($urandom_range(0, 3)), NUM_COLS'($urandom));
        end
        read_session();
      end
      phase_no++;
    end

    // Drain and let the block settle before the verdict.
    park();
    repeat (4) @(posedge clk);
    $display("Sent %0d ticks in %0d reads under %0d register settings.",
             n_items, n_reads, n_settings);
    $display("Compared %0d result words; %0d keys were latched.", words_checked, keys_latched);
    if (fail_count == 0) begin
      $display("tb_keypad_matrix_scanner passed");
    end else begin
      $display("tb_keypad_matrix_scanner failed");
    end
    $finish;
  end

endmodule
